FILE: rtl/core/twcn_pkg.sv
// Shared constants and types for the tileable cellular noise unit.
package twcn_pkg;

  localparam int FRAC_BITS = 24;
  localparam int NLANE     = 27;

  localparam logic [31:0] HASH_KX = 32'h8DA6B343;
  localparam logic [31:0] HASH_KY = 32'hD8163841;
  localparam logic [31:0] HASH_KZ = 32'hCB1AB31F;
  localparam logic [31:0] HASH_KS = 32'h165667B1;
  localparam logic [31:0] MIX_K1  = 32'h2C1B3C6D;
  localparam logic [31:0] MIX_K2  = 32'h297A2D39;
  localparam logic [23:0] OFS_KY  = 24'h3779B1;
  localparam logic [23:0] OFS_KZ  = 24'hEBCA6B;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [7:0]  DENS_SCALE = 8'd255;
  localparam logic [24:0] ROUND_Q16  = 25'h8000;

  typedef logic [25:0] mag_t;   // |offset| per axis, 24 fraction bits
  typedef logic [53:0] dist_t;  // squared distance, 48 fraction bits
  typedef logic [23:0] frac_t;

endpackage

FILE: rtl/core/tileable_worley_cell_noise_unit.sv
// Top level: pipelined 3-D tileable Worley F1 noise, one texel per cycle unless res_stall holds the output.
//
// Request channel: req_valid/req_stall with u_coord, v_coord, w_coord,
// cell_grid and noise_seed. A request is taken on a rising edge with
// req_valid high and req_stall low. Result channel: res_valid/res_stall
// with density, one result per request, in request order.
// A cell_grid of zero acts as 1; values above MAX_GRID saturate.
// The pipeline has 17 register stages. Throughput is one request per cycle
// while res_stall does not hold the output: all 27 neighbor cells are hashed
// in parallel lanes, the nearest one is found by a registered three-level min
// tree, and the square root is a four-stage digit pipeline, four root bits
// per stage.
// The whole pipeline advances as one; while a result waits under
// res_stall, every stage holds and req_stall is raised, so nothing is lost
// or repeated. Bubbles move forward whenever the output is free.
// Synchronous reset clears all stage valid bits; the data registers are not reset.
module tileable_worley_cell_noise_unit #(
  parameter int MAX_GRID   = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [COORD_BITS-1:0]          u_coord,
  input  logic [COORD_BITS-1:0]          v_coord,
  input  logic [COORD_BITS-1:0]          w_coord,
  input  logic [$clog2(MAX_GRID+1)-1:0]  cell_grid,
  input  logic [31:0]                    noise_seed,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [7:0]                     density
);

  localparam int GRID_W = $clog2(MAX_GRID + 1);
  localparam int CELL_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int NST    = 17;
  localparam int FB     = twcn_pkg::FRAC_BITS;
  localparam int NL     = twcn_pkg::NLANE;

  logic             en;
  logic [NST:1]     vld;

  assign en        = !vld[NST] || !res_stall;
  assign req_stall = !en;
  assign res_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], req_valid};
    end
  end

  // stage 1: clamp grid, scale coordinates
  logic [GRID_W-1:0]            g_cl;
  logic [COORD_BITS+GRID_W-1:0] scl [3];
  logic [COORD_BITS-1:0]        crd [3];
  logic [GRID_W-1:0]            grid1;
  logic [CELL_W-1:0]            cell1 [3];
  logic [31:0]                  seed1;
  twcn_pkg::frac_t              frac_p [1:6][3];

  assign crd[0] = u_coord;
  assign crd[1] = v_coord;
  assign crd[2] = w_coord;

  always_comb begin
    if (cell_grid == '0) begin
      g_cl = GRID_W'(1);
    end else if (cell_grid > GRID_W'(MAX_GRID)) begin
      g_cl = GRID_W'(MAX_GRID);
    end else begin
      g_cl = cell_grid;
    end
    for (int a = 0; a < 3; a++) begin
      scl[a] = (COORD_BITS+GRID_W)'(crd[a]) * (COORD_BITS+GRID_W)'(g_cl);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grid1 <= g_cl;
      seed1 <= noise_seed;
      for (int a = 0; a < 3; a++) begin
        cell1[a]     <= CELL_W'(scl[a] >> COORD_BITS);
        frac_p[1][a] <= FB'(scl[a][COORD_BITS-1:0]) << (FB - COORD_BITS);
      end
      for (int s = 2; s <= 6; s++) begin
        frac_p[s] <= frac_p[s-1];
      end
    end
  end

  // stage 2: wrapped neighbor cells and their hash products
  logic [GRID_W-1:0] nb   [3][3];
  logic [31:0]       prod2 [3][3];
  logic [31:0]       sprod2;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nb[a][1] = GRID_W'(cell1[a]);
      nb[a][0] = (cell1[a] == '0) ? grid1 - GRID_W'(1) : GRID_W'(cell1[a]) - GRID_W'(1);
      nb[a][2] = (GRID_W'(cell1[a]) == grid1 - GRID_W'(1)) ? '0
                                                           : GRID_W'(cell1[a]) + GRID_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod2[0][k] <= 32'(nb[0][k]) * twcn_pkg::HASH_KX;
        prod2[1][k] <= 32'(nb[1][k]) * twcn_pkg::HASH_KY;
        prod2[2][k] <= 32'(nb[2][k]) * twcn_pkg::HASH_KZ;
      end
      sprod2 <= seed1 * twcn_pkg::HASH_KS;
    end
  end

  // stages 3..6: per-lane hash finalizer and feature offsets
  logic [31:0]     h3 [NL];
  logic [31:0]     h4 [NL];
  logic [31:0]     h5 [NL];
  twcn_pkg::frac_t hx6 [NL];
  twcn_pkg::frac_t hy6 [NL];
  twcn_pkg::frac_t hz6 [NL];
  logic [31:0]     sum3 [NL];
  logic [31:0]     mix4 [NL];
  logic [31:0]     mix6 [NL];

  always_comb begin
    for (int dz = 0; dz < 3; dz++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          sum3[dz*9+dy*3+dx] = prod2[0][dx] + prod2[1][dy] + prod2[2][dz] + sprod2;
        end
      end
    end
    for (int l = 0; l < NL; l++) begin
      mix4[l] = h4[l] ^ (h4[l] >> 12);
      mix6[l] = h5[l] ^ (h5[l] >> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        h3[l]  <= sum3[l] ^ (sum3[l] >> 15);
        h4[l]  <= h3[l] * twcn_pkg::MIX_K1;
        h5[l]  <= mix4[l] * twcn_pkg::MIX_K2;
        hx6[l] <= mix6[l][23:0];
        hy6[l] <= mix6[l][23:0] * twcn_pkg::OFS_KY + 24'd1;
        hz6[l] <= mix6[l][23:0] * twcn_pkg::OFS_KZ + 24'd2;
      end
    end
  end

  // stage 7: offset magnitudes; stage 8: squares; stage 9: sums
  logic signed [26:0] ofs  [NL][3];
  twcn_pkg::mag_t     mag7 [NL][3];
  logic [51:0]        sq8  [NL][3];
  twcn_pkg::dist_t    d9   [NL];

  always_comb begin
    for (int dz = 0; dz < 3; dz++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          ofs[dz*9+dy*3+dx][0] = 27'(signed'(dx - 1)) * 27'sd16777216
                               + signed'(27'(hx6[dz*9+dy*3+dx])) - signed'(27'(frac_p[6][0]));
          ofs[dz*9+dy*3+dx][1] = 27'(signed'(dy - 1)) * 27'sd16777216
                               + signed'(27'(hy6[dz*9+dy*3+dx])) - signed'(27'(frac_p[6][1]));
          ofs[dz*9+dy*3+dx][2] = 27'(signed'(dz - 1)) * 27'sd16777216
                               + signed'(27'(hz6[dz*9+dy*3+dx])) - signed'(27'(frac_p[6][2]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        for (int a = 0; a < 3; a++) begin
          mag7[l][a] <= ofs[l][a][26] ? 26'(-ofs[l][a]) : 26'(ofs[l][a]);
          sq8[l][a]  <= 52'(mag7[l][a]) * 52'(mag7[l][a]);
        end
        d9[l] <= 54'(sq8[l][0]) + 54'(sq8[l][1]) + 54'(sq8[l][2]);
      end
    end
  end

  // stages 10..12: registered min tree, 27 -> 9 -> 3 -> 1
  twcn_pkg::dist_t m10 [9];
  twcn_pkg::dist_t m11 [3];
  twcn_pkg::dist_t best12;

  function automatic twcn_pkg::dist_t min3(twcn_pkg::dist_t a, twcn_pkg::dist_t b,
                                           twcn_pkg::dist_t c);
    twcn_pkg::dist_t m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        m10[k] <= min3(d9[3*k], d9[3*k+1], d9[3*k+2]);
      end
      for (int k = 0; k < 3; k++) begin
        m11[k] <= min3(m10[3*k], m10[3*k+1], m10[3*k+2]);
      end
      best12 <= min3(m11[0], m11[1], m11[2]);
    end
  end

  // stages 13..16: square root of best >> 16, four root bits per stage.
  // A radicand of 2^32 or more clamps the distance to 1.0.
  logic [17:0] rem_s  [4];
  logic [15:0] root_s [4];
  logic [31:0] rad_s  [4];
  logic        big_s  [4];
  logic [17:0] rem_n  [4];
  logic [15:0] root_n [4];
  logic [31:0] rad_n  [4];

  always_comb begin
    logic [17:0] r_in;
    logic [15:0] q_in;
    logic [31:0] v_in;
    logic [19:0] acc;
    logic [19:0] trial;
    for (int s = 0; s < 4; s++) begin
      if (s == 0) begin
        r_in = '0;
        q_in = '0;
        v_in = best12[47:16];
      end else begin
        r_in = rem_s[s-1];
        q_in = root_s[s-1];
        v_in = rad_s[s-1];
      end
      for (int i = 0; i < 4; i++) begin
        acc   = {r_in, v_in[31:30]};
        trial = {2'b00, q_in, 2'b01};
        v_in  = v_in << 2;
        if (acc >= trial) begin
          r_in = 18'(acc - trial);
          q_in = {q_in[14:0], 1'b1};
        end else begin
          r_in = 18'(acc);
          q_in = {q_in[14:0], 1'b0};
        end
      end
      rem_n[s]  = r_in;
      root_n[s] = q_in;
      rad_n[s]  = v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < 4; s++) begin
        rem_s[s]  <= rem_n[s];
        root_s[s] <= root_n[s];
        rad_s[s]  <= rad_n[s];
        big_s[s]  <= (s == 0) ? (|best12[53:48]) : big_s[s-1];
      end
    end
  end

  // stage 17: invert and scale to a byte
  logic [16:0] inv;
  logic [24:0] scaled;
  logic        big17;

  assign inv    = big_s[3] ? '0 : twcn_pkg::ONE_Q16 - 17'(root_s[3]);
  assign scaled = 25'(inv) * 25'(twcn_pkg::DENS_SCALE) + twcn_pkg::ROUND_Q16;

  always_ff @(posedge clk) begin
    if (en) begin
      density <= scaled[23:16];
      big17   <= big_s[3];
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> $stable(vld))
    else $error("pipeline moved while result stalled");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("valid bits not cleared by reset");

  a_far_is_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && big17) |-> (density == 8'd0))
    else $error("clamped distance gave nonzero density");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (vld[16] && !big_s[3]) |-> (32'(root_s[3]) * 32'(root_s[3]) <= 32'hFFFE0001))
    else $error("root out of range");
`endif

endmodule

FILE: verif/tb_tileable_worley_cell_noise_unit.sv
// Self-checking testbench for the tileable Worley cellular noise unit.
module tb_tileable_worley_cell_noise_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXG = 256;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [15:0] u_coord = '0, v_coord = '0, w_coord = '0;
  logic [8:0]  cell_grid = 9'd1;
  logic [31:0] noise_seed = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [7:0]  density;

  logic [7:0] density_q[$];
  int         errors = 0;
  int         idle_pct = 30;

  tileable_worley_cell_noise_unit #(.MAX_GRID(MAXG), .COORD_BITS(16)) uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] cell_mix(logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic [31:0] s);
    logic [31:0] h;
    h = x * 32'h8DA6B343 + y * 32'hD8163841 + z * 32'hCB1AB31F + s * 32'h165667B1;
    h = h ^ (h >> 15);
    h = h * 32'h2C1B3C6D;
    h = h ^ (h >> 12);
    h = h * 32'h297A2D39;
    h = h ^ (h >> 15);
    return h;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] predict_density(logic [15:0] u, logic [15:0] v,
      logic [15:0] w, logic [8:0] grid, logic [31:0] seed);
    longint g, c[3], f[3], o[3], s, best, d;
    logic [15:0] co[3];
    logic [31:0] h, hh[3], wc[3];
    bit have;
    g = grid;
    if (g == 0) g = 1;
    if (g > MAXG) g = MAXG;
    co[0] = u; co[1] = v; co[2] = w;
    for (int i = 0; i < 3; i++) begin
      s = longint'(co[i]) * g;
      c[i] = s >>> 16;
      f[i] = (s & 64'hFFFF) << 8;
    end
    have = 0;
    best = 0;
    for (int dz = -1; dz <= 1; dz++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          wc[0] = 32'((c[0] + dx + g) % g);
          wc[1] = 32'((c[1] + dy + g) % g);
          wc[2] = 32'((c[2] + dz + g) % g);
          h = cell_mix(wc[0], wc[1], wc[2], seed);
          hh[0] = h & 32'hFFFFFF;
          hh[1] = (h * 32'h9E3779B1 + 32'd1) & 32'hFFFFFF;
          hh[2] = (h * 32'h85EBCA6B + 32'd2) & 32'hFFFFFF;
          o[0] = longint'(dx) * (64'd1 << 24) + hh[0] - f[0];
          o[1] = longint'(dy) * (64'd1 << 24) + hh[1] - f[1];
          o[2] = longint'(dz) * (64'd1 << 24) + hh[2] - f[2];
          s = o[0] * o[0] + o[1] * o[1] + o[2] * o[2];
          if (!have || s < best) begin
            best = s;
            have = 1;
          end
        end
    d = root64(best >> 16);
    if (d > 65536) d = 65536;
    return 8'((((65536 - d) * 255) + 32768) >> 16);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // req_valid stays high between back-to-back requests and drops only while idling
  task automatic send_request(logic [15:0] u, logic [15:0] v, logic [15:0] w,
                              logic [8:0] grid, logic [31:0] seed);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    u_coord <= u; v_coord <= v; w_coord <= w;
    cell_grid <= grid; noise_seed <= seed;
    density_q.push_back(predict_density(u, v, w, grid, seed));
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // result check and random stall
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (density_q.size() == 0) report_mismatch("result with no request pending");
        else begin
          if (density !== density_q[0])
            report_mismatch($sformatf("density got %0d want %0d", density, density_q[0]));
          void'(density_q.pop_front());
        end
      end
      res_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic test_extremes();
    send_request(0, 0, 0, 1, 0);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 256, 32'hFFFFFFFF);
    send_request(16'hFFFF, 0, 16'h8000, 2, 32'h12345678);
    send_request(0, 16'hFFFF, 1, 0, 32'hDEADBEEF);   // zero grid
    send_request(16'h1234, 16'h5678, 16'h9ABC, 9'h1FF, 32'h1); // oversized grid
    send_request(16'h8000, 16'h8000, 16'h8000, 257, 32'h80000000);
    send_request(16'h5555, 16'hAAAA, 16'h5555, 3, 32'h55555555);
    send_request(16'hAAAA, 16'h5555, 16'hAAAA, 255, 32'hAAAAAAAA);
    for (int g = 0; g < 6; g++) send_request(16'h4000, 16'hC000, 16'h0001, 9'(g), 32'h0);
  endtask

  task automatic test_random(int n);
    logic [8:0] g;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: g = 9'($urandom_range(1, 4));
        1: g = 9'($urandom_range(1, 256));
        2: g = 9'($urandom);
        default: g = 9'($urandom_range(254, 256));
      endcase
      send_request(16'($urandom), 16'($urandom), 16'($urandom), g, $urandom);
    end
  endtask

  task automatic test_back_to_back(int n);
    idle_pct = 0;
    test_random(n);
    idle_pct = 30;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random(450);
    test_back_to_back(200);
    test_random(300);
    req_valid <= 1'b0;
    while (density_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
